// ----- design/pidar_pkg.sv -----
// ----------------------------------------------------------------------------
// pidar_pkg
// Shared types and codes for the positional insert/delete array list.
// ----------------------------------------------------------------------------
`default_nettype none

package pidar_pkg;

  // Request kinds
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // Result status codes
  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  localparam int unsigned CAP_W = 5;
  localparam int unsigned POS_W = 5;
  localparam int unsigned VAL_W = 32;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] removed_value;
    logic                    status;
    logic [CAP_W-1:0]        count_after;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the request
    logic exec;   // carry out the captured request
  } cmd_t;

endpackage

`default_nettype wire

// ----- design/positional_insert_delete_array_top.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_array_top
// Packed list of signed 32-bit entries: append, insert at, delete at.
// ----------------------------------------------------------------------------
// Flow: a taken request is captured into the request register, then executed;
//   the result and its strobe are registered together at the execute edge.
// Requests: a new request is taken only while idle; busy is high for the execute
//   cycle while the entry cells that move shift in parallel. The receiver cannot stall.
// Reset (synchronous, active high): list empty, capacity 16, no strobe;
//   entry contents are undefined until written.
`default_nettype none

module positional_insert_delete_array_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request side
  input  wire logic                        start,
  input  wire pidar_pkg::req_t             req,
  output logic                             busy,
  // result side: one transfer per request, valid for exactly one cycle
  output logic                             done,
  output pidar_pkg::rsp_t                  rsp,
  // capacity register write
  input  wire logic                        cfg_we,
  input  wire logic [pidar_pkg::CAP_W-1:0] cfg_data
);
  import pidar_pkg::*;

  cmd_t cmd;

  // Sequence each request: capture, execute, then strobe the result
  pidar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
  );

  // Hold the entries, the fill count and the capacity register
  pidar_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

// ----- design/pidar_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidar_ctrl
// Sequencer: takes a request, runs it through the datapath, flags the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pidar_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output pidar_pkg::cmd_t    cmd,
  output logic               done
);
  import pidar_pkg::*;

  typedef enum logic {IDLE, EXEC} state_t;

  state_t state;

  assign busy     = (state == EXEC);
  assign cmd.load = start && (state == IDLE);
  assign cmd.exec = (state == EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == EXEC);
      unique case (state)
        IDLE: begin
          if (start) state <= EXEC;
        end
        EXEC: begin
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A request is executed in the cycle after its capture
  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec)
    else $error("capture not followed by execute");

  // The strobe marks the cycle right after an execute
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec))
    else $error("result strobe without execute");

endmodule

`default_nettype wire

// ----- design/pidar_dp.sv -----
// ----------------------------------------------------------------------------
// pidar_dp
// Datapath: entry cells with parallel shift, fill count, capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidar_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pidar_pkg::cmd_t                   cmd,
  input  wire pidar_pkg::req_t                   req,
  input  wire logic                              cfg_we,
  input  wire logic [pidar_pkg::CAP_W-1:0]       cfg_data,
  output pidar_pkg::rsp_t                        rsp
);
  import pidar_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned W  = (CW > CAP_W) ? CW : CAP_W;

  logic [VAL_W-1:0]  entries [DEPTH];
  logic [VAL_W-1:0]  from_below [DEPTH];
  logic [VAL_W-1:0]  from_above [DEPTH];
  logic [CW-1:0]     fill_count;
  logic [CW-1:0]     fill_count_next;
  logic [CAP_W-1:0]  capacity;
  req_t              req_q;

  logic [W-1:0]      count_w;
  logic [W-1:0]      pos_w;
  logic [W-1:0]      cap_w;
  logic [W-1:0]      eff_cap;
  logic              ok;
  logic [VAL_W-1:0]  rd_val;

  // Neighbor taps for the shift
  for (genvar g = 0; g < DEPTH; g++) begin : g_taps
    if (g == 0) begin : g_lo
      assign from_below[g] = '0;
    end else begin : g_mid
      assign from_below[g] = entries[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign from_above[g] = '0;
    end else begin : g_top
      assign from_above[g] = entries[g+1];
    end
  end

  assign count_w = W'(fill_count);
  assign pos_w   = W'(req_q.position);
  assign cap_w   = W'(capacity);
  assign eff_cap = (cap_w > W'(DEPTH)) ? W'(DEPTH) : cap_w;

  always_comb begin
    ok = 1'b0;
    unique case (req_q.req_type)
      REQ_APPEND: ok = (count_w < eff_cap);
      REQ_INSERT: ok = (pos_w <= count_w) && (count_w < eff_cap);
      REQ_DELETE: ok = (pos_w < count_w);
      default:    ok = 1'b0;
    endcase
  end

  // Read the entry under the position
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_w == W'(i)) rd_val = entries[i];
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    if (ok) begin
      if (req_q.req_type == REQ_DELETE) fill_count_next = fill_count - CW'(1);
      else                              fill_count_next = fill_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      capacity   <= CAP_W'(16);
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (cmd.exec) fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= req;
    if (cmd.exec) begin
      rsp.removed_value <= (ok && req_q.req_type == REQ_DELETE) ? rd_val : '0;
      rsp.status        <= ok ? ST_DONE : ST_REJECT;
      rsp.count_after   <= CAP_W'(fill_count_next);
    end
  end

  // Each cell moves independently: write, take from below, or take from above
  always_ff @(posedge clk) begin
    if (cmd.exec && ok) begin
      for (int i = 0; i < DEPTH; i++) begin
        priority case (req_q.req_type)
          REQ_APPEND: begin
            if (W'(i) == count_w) entries[i] <= req_q.value_in;
          end
          REQ_INSERT: begin
            if (W'(i) == pos_w) entries[i] <= req_q.value_in;
            else if (W'(i) > pos_w && W'(i) <= count_w) entries[i] <= from_below[i];
          end
          REQ_DELETE: begin
            if (W'(i) >= pos_w && W'(i) + W'(1) < count_w) entries[i] <= from_above[i];
          end
          default: ;
        endcase
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    W'(fill_count) <= W'(DEPTH))
    else $error("fill count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(fill_count))
    else $error("fill count moved without execute");

endmodule

`default_nettype wire
